// ----- sv/hpsc_pkg.sv -----
// Shared types and constants for the heading swing controller.
`default_nettype none

package hpsc_pkg;

    // Stream widths
    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN      = 3'd0,
        REG_DERIV_GAIN     = 3'd1,
        REG_WIDE_WINDOW    = 3'd2,
        REG_WIDE_SETTLE    = 3'd3,
        REG_NARROW_WINDOW  = 3'd4,
        REG_NARROW_SETTLE  = 3'd5
    } cfg_reg_t;

    // Register reset values
    localparam logic [15:0] PROP_GAIN_RST     = 16'd256;
    localparam logic [15:0] DERIV_GAIN_RST    = 16'd0;
    localparam logic [15:0] WIDE_WINDOW_RST   = 16'd768;
    localparam logic [15:0] WIDE_SETTLE_RST   = 16'd50;
    localparam logic [15:0] NARROW_WINDOW_RST = 16'd256;
    localparam logic [15:0] NARROW_SETTLE_RST = 16'd10;

    // Saturation limits of the drive and of the window counts
    localparam logic [15:0] DRIVE_MAX = 16'h7FFF;
    localparam logic [15:0] DRIVE_MIN = 16'h8000;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // Flags that travel with an item down the pipeline
    typedef struct packed {
        logic drive_en;
        logic side;
        logic running;
        logic finished;
    } step_flags_t;

    // Control step result: error and its change
    typedef struct packed {
        logic [25:0] err;
        logic [26:0] der;
        step_flags_t flags;
    } step_s1_t;

    // Gain products
    typedef struct packed {
        logic [42:0] prod_p;
        logic [43:0] prod_d;
        step_flags_t flags;
    } step_s2_t;

endpackage

`default_nettype wire

// ----- sv/heading_pd_swing_controller.sv -----
// Heading swing controller: PD drive of one side with settle detection, top level.
// A result passes through the s1, s2 and output registers after its input transaction is accepted.
// Throughput: one transaction per cycle unless a stalled output holds s_tready low; the move
// state is updated at acceptance, so the next tick can follow in the next cycle. The two gain
// multiplies sit in a stage of their own, the sum, shift and saturation in the output stage.
// Reset (aresetn low, synchronous): registers return to their reset values, the
// move goes idle and the pipeline empties.
`default_nettype none

module heading_pd_swing_controller (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // slave: tdata = side[0], target_angle[24:1], tick_limit[40:25], heading[64:41]
    input  wire logic                               s_tvalid,
    output      logic                               s_tready,
    input  wire logic [hpsc_pkg::S_TDATA_W-1:0]     s_tdata,
    // slave: tuser = start_req[0], relative[1]
    input  wire logic [hpsc_pkg::S_TUSER_W-1:0]     s_tuser,
    // master: tdata = left_drive[15:0], right_drive[31:16], running[32]
    output      logic                               m_tvalid,
    input  wire logic                               m_tready,
    output      logic [hpsc_pkg::M_TDATA_W-1:0]     m_tdata,
    // master: tlast = finished
    output      logic                               m_tlast,
    // configuration write port
    input  wire logic                               cfg_wr_en,
    input  wire logic [hpsc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [hpsc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import hpsc_pkg::*;

    // Configuration registers
    logic [15:0] prop_gain_reg, deriv_gain_reg;
    logic [15:0] wide_window_reg, wide_settle_reg;
    logic [15:0] narrow_window_reg, narrow_settle_reg;

    // Move state
    logic signed [24:0] goal_reg, goal_next;
    logic signed [25:0] prev_err_reg, prev_err_next;
    logic [15:0] elapsed_reg, elapsed_next;
    logic [15:0] limit_reg, limit_next;
    logic [15:0] wide_cnt_reg, wide_cnt_next;
    logic [15:0] narrow_cnt_reg, narrow_cnt_next;
    logic        active_reg, active_next;
    logic        side_reg, side_next;

    // Pipeline
    logic     s1_valid_reg, s2_valid_reg, out_valid_reg;
    step_s1_t s1_reg, s1_next;
    step_s2_t s2_reg, s2_next;
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;
    logic     out_last_reg;
    logic     advance, accept;

    // Input fields
    logic               in_start, in_rel, in_side;
    logic signed [23:0] in_target, in_heading;
    logic [15:0]        in_limit;

    // Step working values
    logic signed [24:0] goal_eff, goal_start;
    logic signed [25:0] prev_eff, err;
    logic signed [26:0] der;
    logic [15:0]        elapsed_eff, limit_eff, wide_eff, narrow_eff;
    logic               active_eff, side_eff;
    logic [25:0]        mag;
    logic               in_wide, in_narrow, fin, step_run;
    logic [15:0]        wide_inc, narrow_inc;

    // Output stage working values
    logic signed [44:0] sum;
    logic [36:0]        shifted;
    logic [15:0]        drive, drive_neg, left_drv, right_drv;

    assign in_start   = s_tuser[0];
    assign in_rel     = s_tuser[1];
    assign in_side    = s_tdata[0];
    assign in_target  = s_tdata[24:1];
    assign in_limit   = s_tdata[40:25];
    assign in_heading = s_tdata[64:41];

    // Whole pipeline moves when the output register is free or being taken
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance;
    assign accept   = s_tvalid && advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // Hold configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg     <= PROP_GAIN_RST;
            deriv_gain_reg    <= DERIV_GAIN_RST;
            wide_window_reg   <= WIDE_WINDOW_RST;
            wide_settle_reg   <= WIDE_SETTLE_RST;
            narrow_window_reg <= NARROW_WINDOW_RST;
            narrow_settle_reg <= NARROW_SETTLE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_PROP_GAIN:     prop_gain_reg     <= cfg_wdata;
                REG_DERIV_GAIN:    deriv_gain_reg    <= cfg_wdata;
                REG_WIDE_WINDOW:   wide_window_reg   <= cfg_wdata;
                REG_WIDE_SETTLE:   wide_settle_reg   <= cfg_wdata;
                REG_NARROW_WINDOW: narrow_window_reg <= cfg_wdata;
                REG_NARROW_SETTLE: narrow_settle_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Control step: start handling, budget check, error, window counts
    always_comb begin
        goal_start = in_rel ? (25'(in_heading) + 25'(in_target)) : 25'(in_target);

        goal_eff    = in_start ? goal_start : goal_reg;
        prev_eff    = in_start ? '0 : prev_err_reg;
        elapsed_eff = in_start ? '0 : elapsed_reg;
        limit_eff   = in_start ? in_limit : limit_reg;
        wide_eff    = in_start ? '0 : wide_cnt_reg;
        narrow_eff  = in_start ? '0 : narrow_cnt_reg;
        active_eff  = in_start || active_reg;
        side_eff    = in_start ? in_side : side_reg;

        err = 26'(goal_eff) - 26'(in_heading);
        der = 27'(err) - 27'(prev_eff);
        mag = err[25] ? 26'(-err) : 26'(err);

        in_wide    = mag <= {10'd0, wide_window_reg};
        in_narrow  = mag <= {10'd0, narrow_window_reg};
        wide_inc   = (wide_eff == COUNT_MAX) ? wide_eff : wide_eff + 16'd1;
        narrow_inc = (narrow_eff == COUNT_MAX) ? narrow_eff : narrow_eff + 16'd1;

        goal_next       = goal_eff;
        prev_err_next   = prev_eff;
        elapsed_next    = elapsed_eff;
        limit_next      = limit_eff;
        wide_cnt_next   = wide_eff;
        narrow_cnt_next = narrow_eff;
        side_next       = side_eff;
        fin             = 1'b0;
        step_run        = 1'b0;

        if (active_eff) begin
            if (elapsed_eff >= limit_eff) begin
                fin = 1'b1;
            end else begin
                // wide window first; narrow is only looked at if wide did not end it
                if (in_wide) begin
                    wide_cnt_next = wide_inc;
                    if (wide_inc >= wide_settle_reg) begin
                        fin = 1'b1;
                    end
                end else begin
                    wide_cnt_next = '0;
                end
                if (!fin) begin
                    if (in_narrow) begin
                        narrow_cnt_next = narrow_inc;
                        if (narrow_inc >= narrow_settle_reg) begin
                            fin = 1'b1;
                        end
                    end else begin
                        narrow_cnt_next = '0;
                    end
                end
                if (!fin) begin
                    step_run      = 1'b1;
                    prev_err_next = err;
                    elapsed_next  = elapsed_eff + 16'd1;
                end
            end
        end
        active_next = active_eff && !fin;

        s1_next.err            = err;
        s1_next.der            = der;
        s1_next.flags.drive_en = step_run;
        s1_next.flags.side     = side_eff;
        s1_next.flags.running  = active_next;
        s1_next.flags.finished = fin;
    end

    // Gain products
    always_comb begin
        s2_next.prod_p = 43'($signed({1'b0, prop_gain_reg}) * $signed(s1_reg.err));
        s2_next.prod_d = 44'($signed({1'b0, deriv_gain_reg}) * $signed(s1_reg.der));
        s2_next.flags  = s1_reg.flags;
    end

    // Sum, floor shift by 8, saturate, route to the selected side
    always_comb begin
        sum     = 45'($signed(s2_reg.prod_p)) + 45'($signed(s2_reg.prod_d));
        shifted = sum[44:8];
        if (shifted[36:15] == '0 || shifted[36:15] == '1) begin
            drive = shifted[15:0];
        end else begin
            drive = shifted[36] ? DRIVE_MIN : DRIVE_MAX;
        end
        drive_neg = (drive == DRIVE_MIN) ? DRIVE_MAX : 16'(-drive);
        left_drv  = (s2_reg.flags.drive_en && !s2_reg.flags.side) ? drive : '0;
        right_drv = (s2_reg.flags.drive_en && s2_reg.flags.side) ? drive_neg : '0;
        out_data_next = {7'd0, s2_reg.flags.running, right_drv, left_drv};
    end

    // Advance move state on each accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            goal_reg       <= '0;
            prev_err_reg   <= '0;
            elapsed_reg    <= '0;
            limit_reg      <= '0;
            wide_cnt_reg   <= '0;
            narrow_cnt_reg <= '0;
            active_reg     <= 1'b0;
            side_reg       <= 1'b0;
        end else if (accept) begin
            goal_reg       <= goal_next;
            prev_err_reg   <= prev_err_next;
            elapsed_reg    <= elapsed_next;
            limit_reg      <= limit_next;
            wide_cnt_reg   <= wide_cnt_next;
            narrow_cnt_reg <= narrow_cnt_next;
            active_reg     <= active_next;
            side_reg       <= side_next;
        end
    end

    // Pipeline valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg  <= s_tvalid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    // Pipeline payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_reg       <= s1_next;
            s2_reg       <= s2_next;
            out_data_reg <= out_data_next;
            out_last_reg <= s2_reg.flags.finished;
        end
    end

endmodule

`default_nettype wire

// ----- sv/hpsc_checker.sv -----
// Port-level checks for the heading swing controller, bound to the top level.
`default_nettype none

module hpsc_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [hpsc_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                           m_tlast
);
    import hpsc_pkg::*;

    // Stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // Ending tick drives zero and stops running
    a_end_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[31:0] == 32'd0 && !m_tdata[32])
        else $error("ending tick not zero drive");

    // Only one side is ever driven
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:0] == 16'd0 || m_tdata[31:16] == 16'd0)
        else $error("both sides driven");

    // Empty output register never blocks the input
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with free output");

endmodule

bind heading_pd_swing_controller hpsc_checker u_hpsc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ----- tb/sv/hpsc_drive_checker.sv -----
// Drive predictor and result checker for the heading swing controller testbench.
module hpsc_drive_checker
    import hpsc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic [S_TUSER_W-1:0]  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  m_tlast,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    mismatch_count,
    output int                    pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [15:0] left;
        logic [15:0] right;
        logic        running;
        logic        ended;
    } drive_result_t;

    // Shadow copy of the configuration registers
    logic [15:0] prop_gain, deriv_gain;
    logic [15:0] wide_win, wide_settle, narrow_win, narrow_settle;

    // Move state of the predicted controller
    logic signed [24:0] goal_ang;
    logic signed [25:0] last_err;
    logic [15:0]        ticks_used, tick_budget, wide_run, narrow_run;
    logic               moving, right_side;

    drive_result_t drive_q[$];
    drive_result_t want;

    function automatic longint clip16(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // Advance the move by one control tick and return the drive it produces
    function automatic drive_result_t run_tick(input logic start, input logic rel,
            input logic side_sel, input logic signed [23:0] tgt,
            input logic [15:0] budget, input logic signed [23:0] hdg);
        drive_result_t res;
        longint err, der, drv, mag;
        logic stop;
        res = '{left: '0, right: '0, running: 1'b0, ended: 1'b0};
        stop = 1'b0;
        if (start) begin
            goal_ang    = rel ? 25'(longint'(hdg) + longint'(tgt)) : 25'(longint'(tgt));
            last_err    = '0;
            ticks_used  = '0;
            tick_budget = budget;
            wide_run    = '0;
            narrow_run  = '0;
            right_side  = side_sel;
            moving      = 1'b1;
        end
        if (moving) begin
            if (ticks_used >= tick_budget) begin
                // tick budget spent: end without a control step
                stop = 1'b1;
            end else begin
                err = longint'(goal_ang) - longint'(hdg);
                der = err - longint'(last_err);
                drv = clip16((longint'(prop_gain) * err + longint'(deriv_gain) * der) >>> 8);
                mag = (err < 0) ? -err : err;
                if (mag <= longint'(wide_win)) begin
                    if (wide_run != COUNT_MAX) wide_run++;
                    if (wide_run >= wide_settle) stop = 1'b1;
                end else begin
                    wide_run = '0;
                end
                if (!stop) begin
                    if (mag <= longint'(narrow_win)) begin
                        if (narrow_run != COUNT_MAX) narrow_run++;
                        if (narrow_run >= narrow_settle) stop = 1'b1;
                    end else begin
                        narrow_run = '0;
                    end
                end
                if (!stop) begin
                    if (right_side) res.right = 16'(clip16(-drv));
                    else res.left = 16'(drv);
                    last_err = 26'(err);
                    ticks_used++;
                end
            end
            if (stop) moving = 1'b0;
        end
        res.running = moving;
        res.ended   = stop;
        return res;
    endfunction

    task automatic compare_field(input string what, input logic [15:0] exp_v,
            input logic [15:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, what, $signed(exp_v), $signed(act_v));
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain     = PROP_GAIN_RST;
            deriv_gain    = DERIV_GAIN_RST;
            wide_win      = WIDE_WINDOW_RST;
            wide_settle   = WIDE_SETTLE_RST;
            narrow_win    = NARROW_WINDOW_RST;
            narrow_settle = NARROW_SETTLE_RST;
            goal_ang      = '0;
            last_err      = '0;
            ticks_used    = '0;
            tick_budget   = '0;
            wide_run      = '0;
            narrow_run    = '0;
            moving        = 1'b0;
            right_side    = 1'b0;
            drive_q.delete();
            mismatch_count = 0;
        end else begin
            // track register writes
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_PROP_GAIN:     prop_gain     = cfg_wdata;
                    REG_DERIV_GAIN:    deriv_gain    = cfg_wdata;
                    REG_WIDE_WINDOW:   wide_win      = cfg_wdata;
                    REG_WIDE_SETTLE:   wide_settle   = cfg_wdata;
                    REG_NARROW_WINDOW: narrow_win    = cfg_wdata;
                    REG_NARROW_SETTLE: narrow_settle = cfg_wdata;
                    default: ;
                endcase
            end
            // check a result transaction against the oldest prediction
            if (m_tvalid && m_tready) begin
                if (drive_q.size() == 0) begin
                    $display("%0t: unexpected result, actual tdata %h tlast %b",
                             $time, m_tdata, m_tlast);
                    mismatch_count++;
                end else begin
                    want = drive_q.pop_front();
                    compare_field("left_drive", want.left, m_tdata[15:0]);
                    compare_field("right_drive", want.right, m_tdata[31:16]);
                    compare_field("running", 16'(want.running), 16'(m_tdata[32]));
                    compare_field("finished", 16'(want.ended), 16'(m_tlast));
                end
            end
            // predict the result of an input transaction
            if (s_tvalid && s_tready)
                drive_q.push_back(run_tick(s_tuser[0], s_tuser[1], s_tdata[0],
                                           s_tdata[24:1], s_tdata[40:25], s_tdata[64:41]));
        end
        pending_results <= drive_q.size();
    end

endmodule

// ----- tb/sv/tb.sv -----
// Testbench top: clock, reset, stimulus and verdict for the heading swing controller.
module tb;
    import hpsc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          QUIET_LIMIT = 2000;
    localparam logic [23:0] ANG_MAX     = 24'h7FFFFF;
    localparam logic [23:0] ANG_MIN     = 24'h800000;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [S_TUSER_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int mismatch_count;
    int pending_results;
    int idle_pct    = 0;
    int stall_pct   = 0;
    int quiet_cycles = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    heading_pd_swing_controller u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    hpsc_drive_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    // Stall the result channel at random
    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    // Give up when neither channel moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one tick, with an optional gap before it, and hold until accepted
    task automatic send_tick(input logic start, input logic rel, input logic side_sel,
            input logic [23:0] tgt, input logic [15:0] budget, input logic [23:0] hdg);
        if ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, hdg, budget, tgt, side_sel};
        s_tuser  <= {rel, start};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Drop valid and wait until every predicted result has come out
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    task automatic program_regs(input logic [15:0] kp, input logic [15:0] kd,
            input logic [15:0] ww, input logic [15:0] ws,
            input logic [15:0] nw, input logic [15:0] ns);
        write_reg(REG_PROP_GAIN, kp);
        write_reg(REG_DERIV_GAIN, kd);
        write_reg(REG_WIDE_WINDOW, ww);
        write_reg(REG_WIDE_SETTLE, ws);
        write_reg(REG_NARROW_WINDOW, nw);
        write_reg(REG_NARROW_SETTLE, ns);
        cfg_wr_en <= 1'b0;
    endtask

    // Pick one register value: typical, zero, all ones, or for kind 3 any of those or a random one
    function automatic logic [15:0] pick_reg(input int kind, input int typ_max);
        int r;
        r = (kind == 3) ? int'($urandom_range(3)) : kind;
        case (r)
            1:       return 16'h0000;
            2:       return 16'hFFFF;
            3:       return 16'($urandom);
            default: return 16'($urandom_range(0, typ_max));
        endcase
    endfunction

    function automatic logic [23:0] clamp_angle(input longint v);
        if (v > 8388607) return ANG_MAX;
        if (v < -8388608) return ANG_MIN;
        return 24'(v);
    endfunction

    function automatic logic [15:0] pick_budget();
        case ($urandom_range(9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(1, 30));
        endcase
    endfunction

    // Mostly well-formed moves: a start, then headings closing in on the goal
    task automatic random_phase(input int n_items);
        longint      cur, goal;
        int          left_in_move, r;
        logic        rel;
        logic [23:0] tgt;
        cur = longint'($urandom_range(0, 20000)) - 10000;
        goal = cur;
        left_in_move = 0;
        for (int i = 0; i < n_items; i++) begin
            r = $urandom_range(99);
            if (r < 8) begin
                // noise: any field, any value
                send_tick(1'($urandom_range(1)), 1'($urandom_range(1)),
                          1'($urandom_range(1)),
                          24'($urandom), 16'($urandom), 24'($urandom));
            end else if (left_in_move == 0 || r < 13) begin
                rel = 1'($urandom_range(1));
                if ($urandom_range(9) == 0)
                    tgt = 24'($urandom);
                else
                    tgt = clamp_angle((rel ? 0 : cur)
                                      + longint'($urandom_range(0, 6000)) - 3000);
                goal = rel ? cur + longint'($signed(tgt)) : longint'($signed(tgt));
                send_tick(1'b1, rel, 1'($urandom_range(1)), tgt, pick_budget(),
                          clamp_angle(cur));
                left_in_move = $urandom_range(2, 40);
            end else begin
                // close half the gap with a little sensor noise, now and then jump
                cur = cur + (goal - cur) / 2 + longint'($urandom_range(0, 64)) - 32;
                if ($urandom_range(19) == 0) cur = longint'($signed(24'($urandom)));
                cur = longint'($signed(clamp_angle(cur)));
                send_tick(1'b0, 1'($urandom_range(1)), 1'($urandom_range(1)),
                          24'($urandom), 16'($urandom), clamp_angle(cur));
                left_in_move--;
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: idle ticks at the heading extremes, zero budget, saturation
        send_tick(1'b0, 1'b0, 1'b0, 24'd0, 16'd0, ANG_MAX);
        send_tick(1'b0, 1'b0, 1'b0, 24'd0, 16'd0, ANG_MIN);
        send_tick(1'b1, 1'b0, 1'b0, 24'd500, 16'd0, 24'd0);
        send_tick(1'b1, 1'b0, 1'b0, ANG_MAX, 16'hFFFF, ANG_MIN);
        send_tick(1'b0, 1'b0, 1'b0, 24'd0, 16'd0, ANG_MAX);
        // right side with the most negative drive, then a zero error
        send_tick(1'b1, 1'b0, 1'b1, ANG_MIN, 16'hFFFF, ANG_MAX);
        send_tick(1'b0, 1'b0, 1'b0, 24'd0, 16'd0, ANG_MIN);
        // relative goal, budget of two ticks runs out
        send_tick(1'b1, 1'b1, 1'b1, ANG_MAX, 16'd2, ANG_MAX);
        send_tick(1'b0, 1'b0, 1'b0, 24'd0, 16'd0, ANG_MAX);
        send_tick(1'b0, 1'b0, 1'b0, 24'd0, 16'd0, ANG_MAX);
        send_tick(1'b0, 1'b0, 1'b0, 24'd0, 16'd0, 24'd100);
        // relative goal below the angle range, then restart while moving
        send_tick(1'b1, 1'b1, 1'b0, ANG_MIN, 16'd5, ANG_MIN);
        send_tick(1'b1, 1'b0, 1'b0, 24'd100, 16'd5, 24'd0);
        wait_for_drain();

        // Gains at maximum, windows and settle limits at zero
        program_regs(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_tick(1'b1, 1'b0, 1'b0, 24'd5, 16'd100, 24'd5);
        send_tick(1'b1, 1'b0, 1'b1, 24'd1000, 16'd100, 24'd0);
        send_tick(1'b0, 1'b0, 1'b0, 24'd0, 16'd0, 24'd2000);
        send_tick(1'b0, 1'b0, 1'b0, 24'd0, 16'd0, 24'd1000);
        wait_for_drain();

        // Wide windows, narrow settle limit of zero ends the move first
        program_regs(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
        send_tick(1'b1, 1'b0, 1'b0, 24'd0, 16'd50, 24'd60000);
        send_tick(1'b1, 1'b0, 1'b1, 24'd0, 16'd50, 24'd70000);
        send_tick(1'b0, 1'b0, 1'b0, 24'd0, 16'd0, 24'd0);
        wait_for_drain();

        // Random moves across idling phases and register settings
        for (int ph = 0; ph < 8; ph++) begin
            case (ph / 2)
                0:       begin idle_pct = 0;  stall_pct <= 0;  end
                1:       begin idle_pct = 67; stall_pct <= 0;  end
                2:       begin idle_pct = 0;  stall_pct <= 67; end
                default: begin idle_pct = 21; stall_pct <= 21; end
            endcase
            program_regs(pick_reg(ph % 4, 2048), pick_reg(ph % 4, 2048),
                         pick_reg(ph % 4, 2000), pick_reg(ph % 4, 12),
                         pick_reg(ph % 4, 800), pick_reg(ph % 4, 8));
            random_phase(85);
            wait_for_drain();
        end

        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && pending_results == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- heading_pd_swing_controller.f -----
sv/hpsc_pkg.sv
sv/heading_pd_swing_controller.sv
sv/hpsc_checker.sv
tb/sv/hpsc_drive_checker.sv
tb/sv/tb.sv
